// ----- rtl/cmsq_pkg.sv -----
package cmsq_pkg;

  // Item command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_RESET = 3'd3;
  localparam logic [2:0] CMD_SET   = 3'd4;

  // Event codes reported with every result
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_RUN       = 4'd1;
  localparam logic [3:0] EV_STOP      = 4'd2;
  localparam logic [3:0] EV_FWD_LIMIT = 4'd3;
  localparam logic [3:0] EV_REV_LIMIT = 4'd4;
  localparam logic [3:0] EV_IGNORED   = 4'd5;
  localparam logic [3:0] EV_RUN_CMD   = 4'd6;
  localparam logic [3:0] EV_STOP_CMD  = 4'd7;
  localparam logic [3:0] EV_RESET     = 4'd8;
  localparam logic [3:0] EV_SET       = 4'd9;

  // Debounced pin positions
  localparam int unsigned NUM_PINS  = 5;
  localparam int unsigned PIN_START = 0;
  localparam int unsigned PIN_STOP  = 1;
  localparam int unsigned PIN_EMERG = 2;
  localparam int unsigned PIN_FWD   = 3;
  localparam int unsigned PIN_REV   = 4;

  localparam logic [3:0]        DEBOUNCE_RESET = 4'd2;
  localparam logic signed [7:0] SPEED_RESET    = 8'sd50;
  localparam logic signed [7:0] SPEED_MAX      = 8'sd100;

  // duty = floor(speed * 1023 / 100) as a multiply by a scaled reciprocal
  localparam int unsigned DUTY_SHIFT = 16;
  localparam logic [19:0] DUTY_RECIP = 20'd670434;

  typedef struct packed {
    logic [2:0]        cmd;
    logic              dir_given;
    logic              dir_reverse;
    logic              speed_given;
    logic signed [7:0] speed_value;
    logic              led_given;
    logic              led_value;
  } req_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic              dir;
    logic signed [7:0] speed;
    logic              in1;
    logic              in2;
    logic [9:0]        duty;
    logic              status_led;
    logic              alarm_led;
  } drive_t;

endpackage

// ----- rtl/cmsq_in_if.sv -----
interface cmsq_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic              start_pin;
  logic              stop_pin;
  logic              emerg_pin;
  logic              fwd_limit_pin;
  logic              rev_limit_pin;
  logic              dir_given;
  logic              dir_reverse;
  logic              speed_given;
  logic signed [7:0] speed_value;
  logic              led_given;
  logic              led_value;

  modport source (
    output valid, cmd, start_pin, stop_pin, emerg_pin, fwd_limit_pin, rev_limit_pin,
    output dir_given, dir_reverse, speed_given, speed_value, led_given, led_value,
    input  ready
  );

  modport sink (
    input  valid, cmd, start_pin, stop_pin, emerg_pin, fwd_limit_pin, rev_limit_pin,
    input  dir_given, dir_reverse, speed_given, speed_value, led_given, led_value,
    output ready
  );
endinterface

// ----- rtl/cmsq_out_if.sv -----
interface cmsq_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        machine_state;
  logic              direction;
  logic signed [7:0] speed_setting;
  logic              bridge_in1;
  logic              bridge_in2;
  logic [9:0]        pwm_duty;
  logic              status_led;
  logic              alarm_led;
  logic [3:0]        event_code;
  logic [4:0]        clean_inputs;

  modport source (
    output valid, machine_state, direction, speed_setting, bridge_in1, bridge_in2,
    output pwm_duty, status_led, alarm_led, event_code, clean_inputs,
    input  ready
  );

  modport sink (
    input  valid, machine_state, direction, speed_setting, bridge_in1, bridge_in2,
    input  pwm_duty, status_led, alarm_led, event_code, clean_inputs,
    output ready
  );
endinterface

// ----- rtl/cmsq_debounce.sv -----
module cmsq_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tick_i,
  input  logic [3:0]                     ticks_i,
  input  logic [cmsq_pkg::NUM_PINS-1:0]  raw_i,
  output logic [cmsq_pkg::NUM_PINS-1:0]  stable_o,
  output logic [cmsq_pkg::NUM_PINS-1:0]  stable_next_o
);

  logic [cmsq_pkg::NUM_PINS-1:0] stable_q, stable_d;
  logic [3:0]                    cnt_q   [cmsq_pkg::NUM_PINS];
  logic [3:0]                    cnt_d   [cmsq_pkg::NUM_PINS];
  logic [3:0]                    cnt_inc [cmsq_pkg::NUM_PINS];

  // Each lane is independent: clear on agreement, else count and flip at the limit
  always_comb begin
    for (int i = 0; i < cmsq_pkg::NUM_PINS; i++) begin
      cnt_inc[i]  = cnt_q[i] + 4'd1;
      stable_d[i] = stable_q[i];
      cnt_d[i]    = cnt_inc[i];
      if (raw_i[i] == stable_q[i]) begin
        cnt_d[i] = 4'd0;
      end else if (cnt_inc[i] >= ticks_i) begin
        stable_d[i] = raw_i[i];
        cnt_d[i]    = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '1;
      for (int i = 0; i < cmsq_pkg::NUM_PINS; i++) begin
        cnt_q[i] <= 4'd0;
      end
    end else if (tick_i) begin
      stable_q <= stable_d;
      for (int i = 0; i < cmsq_pkg::NUM_PINS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  assign stable_o      = stable_q;
  assign stable_next_o = stable_d;

endmodule

// ----- rtl/cmsq_duty.sv -----
module cmsq_duty (
  input  logic signed [7:0] speed_i,
  output logic [9:0]        duty_o
);

  logic [6:0]  clamped;
  logic [26:0] prod;

  always_comb begin
    if (speed_i < 8'sd0) begin
      clamped = 7'd0;
    end else if (speed_i > cmsq_pkg::SPEED_MAX) begin
      clamped = 7'(cmsq_pkg::SPEED_MAX);
    end else begin
      clamped = speed_i[6:0];
    end
  end

  assign prod   = 27'(clamped) * 27'(cmsq_pkg::DUTY_RECIP);
  assign duty_o = prod[cmsq_pkg::DUTY_SHIFT +: 10];

endmodule

// ----- rtl/cmsq_fsm.sv -----
module cmsq_fsm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  cmsq_pkg::req_t                 req_i,
  input  logic [cmsq_pkg::NUM_PINS-1:0]  clean_i,
  input  logic [9:0]                     drive_duty_i,
  output cmsq_pkg::drive_t               drive_o,
  output logic [3:0]                     event_o
);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_REV   = 3'd2,
    MODE_STOP  = 3'd3,
    MODE_EMERG = 3'd4
  } mode_e;

  mode_e             mode_q, mode_d;
  logic              dir_q, dir_d;
  logic signed [7:0] speed_q, speed_d;
  logic [1:0]        bridge_q, bridge_d;
  logic [9:0]        duty_q, duty_d;
  logic              status_q, status_d;
  logic              alarm_q, alarm_d;
  logic [3:0]        event_d;

  logic st, sp, em, lf, lr, run_rev, limit_hit;

  assign st = clean_i[cmsq_pkg::PIN_START];
  assign sp = clean_i[cmsq_pkg::PIN_STOP];
  assign em = clean_i[cmsq_pkg::PIN_EMERG];
  assign lf = clean_i[cmsq_pkg::PIN_FWD];
  assign lr = clean_i[cmsq_pkg::PIN_REV];

  assign run_rev   = (mode_q == MODE_REV);
  assign limit_hit = run_rev ? !lr : !lf;

  always_comb begin
    mode_d   = mode_q;
    dir_d    = dir_q;
    speed_d  = speed_q;
    bridge_d = bridge_q;
    duty_d   = duty_q;
    status_d = status_q;
    alarm_d  = alarm_q;
    event_d  = cmsq_pkg::EV_NONE;
    unique case (req_i.cmd)
      cmsq_pkg::CMD_TICK: begin
        if (!em) begin
          mode_d   = MODE_EMERG;
          bridge_d = 2'b00;
          duty_d   = 10'd0;
          status_d = 1'b0;
          alarm_d  = 1'b1;
        end else begin
          alarm_d = 1'b0;
          unique case (mode_q)
            MODE_IDLE, MODE_STOP: begin
              bridge_d = 2'b00;
              duty_d   = 10'd0;
              status_d = 1'b0;
              if (!st && sp && !(dir_q ? !lr : !lf)) begin
                mode_d  = dir_q ? MODE_REV : MODE_FWD;
                event_d = cmsq_pkg::EV_RUN;
              end
            end
            MODE_FWD, MODE_REV: begin
              // Leaving a run state holds the motor outputs for this tick
              priority if (!sp || !st) begin
                mode_d  = MODE_STOP;
                event_d = cmsq_pkg::EV_STOP;
              end else if (limit_hit) begin
                mode_d  = MODE_STOP;
                event_d = run_rev ? cmsq_pkg::EV_REV_LIMIT : cmsq_pkg::EV_FWD_LIMIT;
              end else begin
                bridge_d = run_rev ? 2'b10 : 2'b01;
                duty_d   = drive_duty_i;
                status_d = 1'b1;
              end
            end
            default: begin
              bridge_d = 2'b00;
              duty_d   = 10'd0;
              status_d = 1'b0;
            end
          endcase
        end
      end
      cmsq_pkg::CMD_START: begin
        if (req_i.dir_given) begin
          dir_d = req_i.dir_reverse;
        end
        if (req_i.speed_given) begin
          speed_d = req_i.speed_value;
        end
        if (mode_q == MODE_EMERG) begin
          event_d = cmsq_pkg::EV_IGNORED;
        end else begin
          mode_d  = dir_d ? MODE_REV : MODE_FWD;
          event_d = cmsq_pkg::EV_RUN_CMD;
        end
      end
      cmsq_pkg::CMD_STOP: begin
        mode_d  = MODE_STOP;
        event_d = cmsq_pkg::EV_STOP_CMD;
      end
      cmsq_pkg::CMD_RESET: begin
        if (mode_q == MODE_EMERG) begin
          mode_d  = MODE_STOP;
          event_d = cmsq_pkg::EV_RESET;
        end
      end
      cmsq_pkg::CMD_SET: begin
        if (req_i.speed_given) begin
          speed_d = req_i.speed_value;
        end
        if (req_i.led_given) begin
          status_d = req_i.led_value;
        end
        event_d = cmsq_pkg::EV_SET;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      dir_q    <= 1'b0;
      speed_q  <= cmsq_pkg::SPEED_RESET;
      bridge_q <= 2'b00;
      duty_q   <= 10'd0;
      status_q <= 1'b0;
      alarm_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      dir_q    <= dir_d;
      speed_q  <= speed_d;
      bridge_q <= bridge_d;
      duty_q   <= duty_d;
      status_q <= status_d;
      alarm_q  <= alarm_d;
    end
  end

  always_comb begin
    drive_o.mode       = mode_q;
    drive_o.dir        = dir_q;
    drive_o.speed      = speed_q;
    drive_o.in1        = bridge_q[0];
    drive_o.in2        = bridge_q[1];
    drive_o.duty       = duty_q;
    drive_o.status_led = status_q;
    drive_o.alarm_led  = alarm_q;
  end

  assign event_o = event_d;

endmodule

// ----- rtl/conveyor_motor_sequencer.sv -----
// Conveyor drive sequencer.
// Input channel (in_i): one transfer per item. A tick item (cmd 0) samples the
// five raw active-low pins, debounces them and steps the run/stop/emergency
// state machine; command items (start, stop, emergency reset, set) change the
// stored state directly. Every item gives exactly one result on out_o.
// Result: machine state, stored direction and speed, H-bridge bits, PWM duty,
// LED levels, an event code and the debounced pin levels.
// Configuration: cfg_we_i writes debounce_ticks from cfg_wdata_i; write only
// while no result is pending.
// Latency: the result is valid in the cycle after the input transfer.
// Throughput: one item per cycle while out_o.ready is high; the state update is
// one pass of next-state logic plus one constant multiply for the duty, all
// between the item and the state/result registers.
// Stall: while a result waits on out_o, in_i.ready follows out_o.ready, so a
// new item is taken in the same cycle the waiting result is transferred.
// Reset: idle, forward, speed 50, pins debounced high, counters clear, motor
// and LEDs off, debounce_ticks 2, no result pending.
module conveyor_motor_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  cmsq_in_if.sink    in_i,
  cmsq_out_if.source out_o
);

  logic [3:0]                    ticks_q;
  logic                          out_valid_q, out_valid_d;
  logic [3:0]                    event_q;
  logic                          accept;
  logic                          tick_en;
  logic [cmsq_pkg::NUM_PINS-1:0] raw_pins;
  logic [cmsq_pkg::NUM_PINS-1:0] clean_q;
  logic [cmsq_pkg::NUM_PINS-1:0] clean_d;
  logic [9:0]                    drive_duty;
  logic [3:0]                    event_d;
  cmsq_pkg::req_t                req;
  cmsq_pkg::drive_t              drive;

  // Take a new item whenever the result slot is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign tick_en    = accept && (in_i.cmd == cmsq_pkg::CMD_TICK);

  assign raw_pins = {in_i.rev_limit_pin, in_i.fwd_limit_pin, in_i.emerg_pin,
                     in_i.stop_pin, in_i.start_pin};

  always_comb begin
    req.cmd         = in_i.cmd;
    req.dir_given   = in_i.dir_given;
    req.dir_reverse = in_i.dir_reverse;
    req.speed_given = in_i.speed_given;
    req.speed_value = in_i.speed_value;
    req.led_given   = in_i.led_given;
    req.led_value   = in_i.led_value;
  end

  cmsq_debounce u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick_en),
    .ticks_i       (ticks_q),
    .raw_i         (raw_pins),
    .stable_o      (clean_q),
    .stable_next_o (clean_d)
  );

  // Duty for the stored speed; used only when a tick keeps the motor running
  cmsq_duty u_duty (
    .speed_i (drive.speed),
    .duty_o  (drive_duty)
  );

  cmsq_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (req),
    .clean_i      (clean_d),
    .drive_duty_i (drive_duty),
    .drive_o      (drive),
    .event_o      (event_d)
  );

  // Hold the result until transferred; load on every input transfer
  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= cmsq_pkg::DEBOUNCE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ticks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_d;
    end
  end

  // State registers only change on a transfer, so they double as the result
  assign out_o.valid         = out_valid_q;
  assign out_o.machine_state = drive.mode;
  assign out_o.direction     = drive.dir;
  assign out_o.speed_setting = drive.speed;
  assign out_o.bridge_in1    = drive.in1;
  assign out_o.bridge_in2    = drive.in2;
  assign out_o.pwm_duty      = drive.duty;
  assign out_o.status_led    = drive.status_led;
  assign out_o.alarm_led     = drive.alarm_led;
  assign out_o.event_code    = event_q;
  assign out_o.clean_inputs  = clean_q;

endmodule

// ----- tb/conveyor_motor_sequencer_test.sv -----
`timescale 1ns / 1ps

module conveyor_motor_sequencer_test;

  // Machine states as reported in machine_state
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FWD    = 3'd1;
  localparam logic [2:0] ST_REV    = 3'd2;
  localparam logic [2:0] ST_HALTED = 3'd3;
  localparam logic [2:0] ST_EMERG  = 3'd4;

  // Command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // All pins released: active-low, so every bit high
  localparam logic [cmsq_pkg::NUM_PINS-1:0] PINS_IDLE = '1;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned MAX_REPORTS = 10;

  // One input transfer: the command fields plus the raw pin levels
  typedef struct packed {
    cmsq_pkg::req_t                req;
    logic [cmsq_pkg::NUM_PINS-1:0] pins;
  } seq_item_t;

  // One result transfer: motor/LED outputs, event and debounced levels
  typedef struct packed {
    cmsq_pkg::drive_t              drive;
    logic [3:0]                    ev;
    logic [cmsq_pkg::NUM_PINS-1:0] clean;
  } seq_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BUSY} rx_style_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  cmsq_in_if  seq_in ();
  cmsq_out_if seq_out ();

  conveyor_motor_sequencer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (seq_in),
    .out_o      (seq_out)
  );

  always #1 clk_i = ~clk_i;

  // Predicted sequencer state, kept in step with every accepted transfer
  logic [2:0]                    mode_q;
  logic                          dir_q;
  logic signed [7:0]             speed_q;
  logic [cmsq_pkg::NUM_PINS-1:0] level_q;
  logic [3:0]                    count_q [cmsq_pkg::NUM_PINS];
  logic                          in1_q, in2_q;
  logic [9:0]                    duty_q;
  logic                          status_q, alarm_q;
  logic [3:0]                    debounce_q;

  seq_result_t due_results [$];
  seq_result_t got, want;

  int unsigned cycles;
  int unsigned faults;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned ev_count [16];
  int unsigned burst_left = 8;
  bit          sender_live;

  rx_style_e   rx_style;
  int unsigned rx_span;
  logic [1:0]  rx_phase = 2'd0;

  // Duty for a stored speed: clamp to 0..100 percent, then scale to ten bits
  // with truncation.
  function automatic logic [9:0] scaled_duty(input logic signed [7:0] spd);
    int pct;
    pct = spd;
    if (pct < 0) pct = 0;
    else if (pct > 100) pct = 100;
    return 10'((pct * 1023) / 100);
  endfunction

  // Advance the predicted state by one item and return the result it gives.
  function automatic seq_result_t step_sequencer(input seq_item_t it);
    seq_result_t r;
    logic [3:0]  ev;
    logic        rev;
    ev = cmsq_pkg::EV_NONE;
    case (it.req.cmd)
      cmsq_pkg::CMD_TICK: begin
        // Debounce: take the raw level after debounce_q differing ticks in a row.
        // A setting of zero behaves as one.
        for (int i = 0; i < cmsq_pkg::NUM_PINS; i++) begin
          if (it.pins[i] == level_q[i]) begin
            count_q[i] = '0;
          end else begin
            count_q[i] = count_q[i] + 4'd1;
            if (count_q[i] >= debounce_q) begin
              level_q[i] = it.pins[i];
              count_q[i] = '0;
            end
          end
        end
        if (!level_q[cmsq_pkg::PIN_EMERG]) begin
          // Emergency overrides everything: motor off, alarm on
          mode_q   = ST_EMERG;
          in1_q    = 1'b0;
          in2_q    = 1'b0;
          duty_q   = '0;
          status_q = 1'b0;
          alarm_q  = 1'b1;
        end else begin
          alarm_q = 1'b0;
          case (mode_q)
            ST_IDLE, ST_HALTED: begin
              in1_q    = 1'b0;
              in2_q    = 1'b0;
              duty_q   = '0;
              status_q = 1'b0;
              // Start button only counts with stop released and no limit
              // reached in the stored direction
              if (!level_q[cmsq_pkg::PIN_START] && level_q[cmsq_pkg::PIN_STOP] &&
                  (dir_q ? level_q[cmsq_pkg::PIN_REV] : level_q[cmsq_pkg::PIN_FWD])) begin
                mode_q = dir_q ? ST_REV : ST_FWD;
                ev     = cmsq_pkg::EV_RUN;
              end
            end
            ST_FWD, ST_REV: begin
              rev = (mode_q == ST_REV);
              // Leaving a run state holds the motor outputs for this tick
              if (!level_q[cmsq_pkg::PIN_STOP] || !level_q[cmsq_pkg::PIN_START]) begin
                mode_q = ST_HALTED;
                ev     = cmsq_pkg::EV_STOP;
              end else if (!(rev ? level_q[cmsq_pkg::PIN_REV]
                                 : level_q[cmsq_pkg::PIN_FWD])) begin
                mode_q = ST_HALTED;
                ev     = rev ? cmsq_pkg::EV_REV_LIMIT : cmsq_pkg::EV_FWD_LIMIT;
              end else begin
                in1_q    = !rev;
                in2_q    = rev;
                duty_q   = scaled_duty(speed_q);
                status_q = 1'b1;
              end
            end
            default: begin
              // Emergency with the pin released: stay put until a reset or stop command
              in1_q    = 1'b0;
              in2_q    = 1'b0;
              duty_q   = '0;
              status_q = 1'b0;
            end
          endcase
        end
      end
      cmsq_pkg::CMD_START: begin
        if (it.req.dir_given) dir_q = it.req.dir_reverse;
        if (it.req.speed_given) speed_q = it.req.speed_value;
        if (mode_q == ST_EMERG) begin
          ev = cmsq_pkg::EV_IGNORED;
        end else begin
          mode_q = dir_q ? ST_REV : ST_FWD;
          ev     = cmsq_pkg::EV_RUN_CMD;
        end
      end
      cmsq_pkg::CMD_STOP: begin
        mode_q = ST_HALTED;
        ev     = cmsq_pkg::EV_STOP_CMD;
      end
      cmsq_pkg::CMD_RESET: begin
        if (mode_q == ST_EMERG) begin
          mode_q = ST_HALTED;
          ev     = cmsq_pkg::EV_RESET;
        end
      end
      cmsq_pkg::CMD_SET: begin
        if (it.req.speed_given) speed_q = it.req.speed_value;
        if (it.req.led_given) status_q = it.req.led_value;
        ev = cmsq_pkg::EV_SET;
      end
      default: ;
    endcase
    r.drive.mode       = mode_q;
    r.drive.dir        = dir_q;
    r.drive.speed      = speed_q;
    r.drive.in1        = in1_q;
    r.drive.in2        = in2_q;
    r.drive.duty       = duty_q;
    r.drive.status_led = status_q;
    r.drive.alarm_led  = alarm_q;
    r.ev               = ev;
    r.clean            = level_q;
    return r;
  endfunction

  // Random content in every field but the command, which is a tick; callers override what matters.
  function automatic seq_item_t rand_item();
    seq_item_t it;
    it.req.cmd         = cmsq_pkg::CMD_TICK;
    it.req.dir_given   = $urandom_range(0, 1);
    it.req.dir_reverse = $urandom_range(0, 1);
    it.req.speed_given = $urandom_range(0, 1);
    it.req.speed_value = $urandom_range(0, 1) ? 8'($urandom_range(0, 100)) : 8'($urandom);
    it.req.led_given   = $urandom_range(0, 1);
    it.req.led_value   = $urandom_range(0, 1);
    it.pins            = 5'($urandom);
    return it;
  endfunction

  function automatic seq_item_t cmd_item(input logic [2:0] cmd, input logic dir_given,
                                         input logic dir_reverse, input logic speed_given,
                                         input logic signed [7:0] speed_value,
                                         input logic led_given, input logic led_value);
    seq_item_t it;
    it.req.cmd         = cmd;
    it.req.dir_given   = dir_given;
    it.req.dir_reverse = dir_reverse;
    it.req.speed_given = speed_given;
    it.req.speed_value = speed_value;
    it.req.led_given   = led_given;
    it.req.led_value   = led_value;
    it.pins            = PINS_IDLE;
    return it;
  endfunction

  function automatic seq_item_t tick_item(input logic [cmsq_pkg::NUM_PINS-1:0] pins);
    seq_item_t it;
    it      = cmd_item(cmsq_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0, 1'b0);
    it.pins = pins;
    return it;
  endfunction

  // Pin pattern with one button pressed or one switch reached
  function automatic logic [cmsq_pkg::NUM_PINS-1:0] press(input int unsigned pin);
    logic [cmsq_pkg::NUM_PINS-1:0] p;
    p      = PINS_IDLE;
    p[pin] = 1'b0;
    return p;
  endfunction

  // Offer one item and hold it until the transfer; predict its result there.
  // Between bursts, usually drop valid for a random gap.
  task automatic send_item(input seq_item_t it);
    seq_result_t r;
    int unsigned gap;
    seq_in.valid         <= 1'b1;
    seq_in.cmd           <= it.req.cmd;
    seq_in.start_pin     <= it.pins[cmsq_pkg::PIN_START];
    seq_in.stop_pin      <= it.pins[cmsq_pkg::PIN_STOP];
    seq_in.emerg_pin     <= it.pins[cmsq_pkg::PIN_EMERG];
    seq_in.fwd_limit_pin <= it.pins[cmsq_pkg::PIN_FWD];
    seq_in.rev_limit_pin <= it.pins[cmsq_pkg::PIN_REV];
    seq_in.dir_given     <= it.req.dir_given;
    seq_in.dir_reverse   <= it.req.dir_reverse;
    seq_in.speed_given   <= it.req.speed_given;
    seq_in.speed_value   <= it.req.speed_value;
    seq_in.led_given     <= it.req.led_given;
    seq_in.led_value     <= it.req.led_value;
    sender_live = 1'b1;
    do @(posedge clk_i); while (!seq_in.ready);
    r = step_sequencer(it);
    due_results.push_back(r);
    ev_count[r.ev]++;
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // Now and then run straight into the next burst
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        seq_in.valid <= 1'b0;
        sender_live = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid if the last transfer left it raised.
  task automatic idle_sender();
    if (sender_live) begin
      seq_in.valid <= 1'b0;
      sender_live = 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_results();
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // Every item gives a result, so with nothing outstanding the block is idle.
  task automatic write_debounce(input logic [3:0] value);
    idle_sender();
    wait_results();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    debounce_q = value;
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic shaped like a real line: pins held for stretches mostly long
  // enough to pass the debounce, with glitches, between commands and noise.
  task automatic run_traffic(input int unsigned n);
    int unsigned                   sent;
    int unsigned                   pick;
    int unsigned                   hold_len;
    int unsigned                   span;
    logic [cmsq_pkg::NUM_PINS-1:0] target;
    seq_item_t                     it;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) target = press(cmsq_pkg::PIN_START);
        else if (pick < 40) target = press(cmsq_pkg::PIN_STOP);
        else if (pick < 52) target = press(cmsq_pkg::PIN_FWD);
        else if (pick < 64) target = press(cmsq_pkg::PIN_REV);
        else if (pick < 72) target = press(cmsq_pkg::PIN_EMERG);
        else if (pick < 80) target = 5'($urandom);
        else target = PINS_IDLE;
        span = (debounce_q == 0) ? 1 : debounce_q;
        hold_len = ($urandom_range(0, 9) < 7) ? $urandom_range(span, span + 6)
                                              : $urandom_range(1, span);
        for (int k = 0; k < hold_len && sent < n; k++) begin
          it      = rand_item();
          it.pins = target;
          // Glitch: flip one pin for a single tick
          if ($urandom_range(0, 9) == 0)
            it.pins[$urandom_range(0, cmsq_pkg::NUM_PINS - 1)] ^= 1'b1;
          send_item(it);
          sent++;
        end
      end else if (pick < 92) begin
        it   = rand_item();
        pick = $urandom_range(0, 99);
        if (pick < 35) it.req.cmd = cmsq_pkg::CMD_START;
        else if (pick < 50) it.req.cmd = cmsq_pkg::CMD_STOP;
        else if (pick < 75) it.req.cmd = cmsq_pkg::CMD_RESET;
        else if (pick < 95) it.req.cmd = cmsq_pkg::CMD_SET;
        else it.req.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        send_item(it);
        sent++;
      end else begin
        // Noise: a tick with every pin random
        send_item(rand_item());
        sent++;
      end
    end
  endtask

  // Walk through every command, both limits, the emergency path and the
  // speed extremes with the reset debounce of two ticks.
  task automatic test_reset_and_commands();
    // Set with nothing given shows the reset state
    send_item(cmd_item(cmsq_pkg::CMD_SET, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0, 1'b0));
    send_item(cmd_item(CMD_SPARE_LO, 1'b1, 1'b1, 1'b1, 8'sd3, 1'b1, 1'b1));
    send_item(cmd_item(CMD_SPARE_HI, 1'b1, 1'b1, 1'b1, 8'sd3, 1'b1, 1'b1));
    // Reset outside emergency changes nothing
    send_item(cmd_item(cmsq_pkg::CMD_RESET, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0, 1'b0));
    // Run forward above full speed: duty clamps to the top
    send_item(cmd_item(cmsq_pkg::CMD_START, 1'b1, 1'b0, 1'b1, 8'sd127, 1'b0, 1'b0));
    send_item(tick_item(PINS_IDLE));
    // Most negative speed drives zero duty; force the status LED low
    send_item(cmd_item(cmsq_pkg::CMD_SET, 1'b0, 1'b0, 1'b1, 8'sh80, 1'b1, 1'b0));
    send_item(tick_item(PINS_IDLE));
    send_item(cmd_item(cmsq_pkg::CMD_STOP, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0, 1'b0));
    // Start without a direction keeps forward
    send_item(cmd_item(cmsq_pkg::CMD_START, 1'b0, 1'b1, 1'b1, 8'sd100, 1'b0, 1'b0));
    repeat (2) send_item(tick_item(press(cmsq_pkg::PIN_FWD)));
    send_item(cmd_item(cmsq_pkg::CMD_START, 1'b1, 1'b1, 1'b0, 8'sd0, 1'b0, 1'b0));
    repeat (2) send_item(tick_item(press(cmsq_pkg::PIN_REV)));
    repeat (2) send_item(tick_item(PINS_IDLE));
    // Start button from stopped: runs in reverse once debounced
    repeat (2) send_item(tick_item(press(cmsq_pkg::PIN_START)));
    send_item(tick_item(PINS_IDLE));
    repeat (2) send_item(tick_item(press(cmsq_pkg::PIN_EMERG)));
    // Start in emergency stores direction and speed but is ignored
    send_item(cmd_item(cmsq_pkg::CMD_START, 1'b1, 1'b0, 1'b1, 8'sd101, 1'b0, 1'b0));
    repeat (2) send_item(tick_item(PINS_IDLE));
    send_item(cmd_item(cmsq_pkg::CMD_RESET, 1'b0, 1'b0, 1'b0, 8'sd0, 1'b0, 1'b0));
  endtask

  task automatic test_debounce_setting(input logic [3:0] value, input int unsigned n);
    write_debounce(value);
    run_traffic(n);
  endtask

  // Random register values, each with one pause mid-way until every result is in.
  task automatic test_random_mix(input int unsigned n);
    for (int c = 0; c < 4; c++) begin
      write_debounce(4'($urandom_range(0, 15)));
      run_traffic(n / 8);
      idle_sender();
      wait_results();
      run_traffic(n / 8);
    end
  endtask

  // Receiver: switch between random stall styles at random, including
  // stretches that never stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      seq_out.ready <= 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_style = rx_style_e'($urandom_range(0, 3));
        rx_span  = $urandom_range(8, 60);
      end
      rx_span--;
      rx_phase++;
      case (rx_style)
        RX_FREE:   seq_out.ready <= 1'b1;
        RX_COIN:   seq_out.ready <= $urandom_range(0, 1);
        RX_SPARSE: seq_out.ready <= (rx_phase == 2'd0);
        default:   seq_out.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && seq_out.valid && seq_out.ready) begin
      got.drive.mode       = seq_out.machine_state;
      got.drive.dir        = seq_out.direction;
      got.drive.speed      = seq_out.speed_setting;
      got.drive.in1        = seq_out.bridge_in1;
      got.drive.in2        = seq_out.bridge_in2;
      got.drive.duty       = seq_out.pwm_duty;
      got.drive.status_led = seq_out.status_led;
      got.drive.alarm_led  = seq_out.alarm_led;
      got.ev               = seq_out.event_code;
      got.clean            = seq_out.clean_inputs;
      results_seen++;
      if (due_results.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding (event %0d)", $realtime, got.ev);
      end else begin
        want = due_results.pop_front();
        if (got.drive.mode !== want.drive.mode || got.drive.dir !== want.drive.dir ||
            got.drive.speed !== want.drive.speed || got.drive.in1 !== want.drive.in1 ||
            got.drive.in2 !== want.drive.in2 || got.drive.duty !== want.drive.duty ||
            got.drive.status_led !== want.drive.status_led ||
            got.drive.alarm_led !== want.drive.alarm_led || got.ev !== want.ev ||
            got.clean !== want.clean) begin
          faults++;
          if (faults <= MAX_REPORTS) begin
            $display("%0t: result %0d mismatch", $realtime, results_seen);
            $display("  exp st=%0d dir=%0d spd=%0d in=%b%b duty=%0d led=%b%b ev=%0d clean=%b",
                     want.drive.mode, want.drive.dir, want.drive.speed, want.drive.in1,
                     want.drive.in2, want.drive.duty, want.drive.status_led,
                     want.drive.alarm_led, want.ev, want.clean);
            $display("  got st=%0d dir=%0d spd=%0d in=%b%b duty=%0d led=%b%b ev=%0d clean=%b",
                     got.drive.mode, got.drive.dir, got.drive.speed, got.drive.in1,
                     got.drive.in2, got.drive.duty, got.drive.status_led,
                     got.drive.alarm_led, got.ev, got.clean);
          end
        end
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               due_results.size());
      $display("FAIL conveyor_motor_sequencer");
      $finish;
    end
  end

  initial begin
    int unsigned kinds;
    // Hold every input at a known level through reset
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    seq_in.valid          = 1'b0;
    seq_in.cmd            = cmsq_pkg::CMD_TICK;
    seq_in.start_pin      = 1'b1;
    seq_in.stop_pin       = 1'b1;
    seq_in.emerg_pin      = 1'b1;
    seq_in.fwd_limit_pin  = 1'b1;
    seq_in.rev_limit_pin  = 1'b1;
    seq_in.dir_given      = 1'b0;
    seq_in.dir_reverse    = 1'b0;
    seq_in.speed_given    = 1'b0;
    seq_in.speed_value    = '0;
    seq_in.led_given      = 1'b0;
    seq_in.led_value      = 1'b0;

    // Predicted state after reset
    mode_q     = ST_IDLE;
    dir_q      = 1'b0;
    speed_q    = cmsq_pkg::SPEED_RESET;
    level_q    = PINS_IDLE;
    in1_q      = 1'b0;
    in2_q      = 1'b0;
    duty_q     = '0;
    status_q   = 1'b0;
    alarm_q    = 1'b0;
    debounce_q = cmsq_pkg::DEBOUNCE_RESET;
    for (int i = 0; i < cmsq_pkg::NUM_PINS; i++) count_q[i] = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_commands();
    // Extremes of the register: one tick, the longest count, and zero
    test_debounce_setting(4'd1, 300);
    test_debounce_setting(4'd15, 350);
    test_debounce_setting(4'd0, 250);
    test_random_mix(720);

    // Drain the outstanding results before the summary
    idle_sender();
    wait_results();
    repeat (4) @(posedge clk_i);

    kinds = 0;
    for (int e = 0; e < 16; e++) if (ev_count[e] != 0) kinds++;
    $display("Covered %0d items and %0d results over debounce 0, 1, 2, 15 and random values",
             items_sent, results_seen);
    $display("Distinct event codes seen: %0d, emergency resets: %0d, mismatches: %0d",
             kinds, ev_count[cmsq_pkg::EV_RESET], faults);
    if (faults == 0) begin
      $display("PASS conveyor_motor_sequencer");
    end else begin
      $display("FAIL conveyor_motor_sequencer");
    end
    $finish;
  end

endmodule
